// ===== rtl/vole_machine_step_assert.svh =====
// assertion macros for the vole machine step block
`ifndef VOLE_MACHINE_STEP_ASSERT_SVH
`define VOLE_MACHINE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define VMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VMS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define VMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/vms_pkg.sv =====
// shared types and constants of the vole machine step block
`timescale 1ns / 1ps
`default_nettype none

package vms_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 8;
    localparam int WORD_W      = 16;
    localparam int REG_IDX_W   = 4;
    localparam int REG_DEPTH   = 16;
    localparam int BANK_ADDR_W = ADDR_W - 1;
    localparam int BANK_DEPTH  = 2 ** BANK_ADDR_W;

    localparam logic [ADDR_W-1:0] START_ADDRESS_RESET = 8'd48;

    localparam logic ITEM_WRITE = 1'b0;
    localparam logic ITEM_EXEC  = 1'b1;

    localparam logic [3:0] OP_LOAD  = 4'h1;
    localparam logic [3:0] OP_LOADI = 4'h2;
    localparam logic [3:0] OP_STORE = 4'h3;
    localparam logic [3:0] OP_MOVE  = 4'h4;
    localparam logic [3:0] OP_ADD   = 4'h5;
    localparam logic [3:0] OP_JUMP  = 4'hB;
    localparam logic [3:0] OP_HALT  = 4'hC;

    localparam logic [REG_IDX_W-1:0] REG_R0 = 4'd0;

    typedef struct packed {
        logic                   we;
        logic [BANK_ADDR_W-1:0] waddr;
        logic [DATA_W-1:0]      wdata;
        logic                   re;
        logic [BANK_ADDR_W-1:0] raddr;
    } bank_req_t;

    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] waddr;
        logic [DATA_W-1:0]    wdata;
        logic                 re;
        logic [REG_IDX_W-1:0] raddr_a;
        logic [REG_IDX_W-1:0] raddr_b;
    } rf_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    pc_after;
        logic [WORD_W-1:0]    executed_word;
        logic                 is_halted;
        logic                 zero_fetch;
        logic                 screen_valid;
        logic [DATA_W-1:0]    screen_byte;
        logic                 reg_written;
        logic [REG_IDX_W-1:0] reg_number;
        logic [DATA_W-1:0]    reg_value;
    } rsp_payload_t;

endpackage

`default_nettype wire

// ===== rtl/vms_req_if.sv =====
// request channel: program byte writes and execute commands
`timescale 1ns / 1ps
`default_nettype none

interface vms_req_if
    import vms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output opcode, output address, output data, input ready);
    modport sink   (input valid, input opcode, input address, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/vms_rsp_if.sv =====
// response channel: one result per request transfer
`timescale 1ns / 1ps
`default_nettype none

interface vms_rsp_if
    import vms_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    pc_after;
    logic [WORD_W-1:0]    executed_word;
    logic                 is_halted;
    logic                 zero_fetch;
    logic                 screen_valid;
    logic [DATA_W-1:0]    screen_byte;
    logic                 reg_written;
    logic [REG_IDX_W-1:0] reg_number;
    logic [DATA_W-1:0]    reg_value;

    modport source (
        output valid, output pc_after, output executed_word, output is_halted,
        output zero_fetch, output screen_valid, output screen_byte,
        output reg_written, output reg_number, output reg_value,
        input ready
    );
    modport sink (
        input valid, input pc_after, input executed_word, input is_halted,
        input zero_fetch, input screen_valid, input screen_byte,
        input reg_written, input reg_number, input reg_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/vms_mem_bank.sv =====
// one half of main memory (even or odd bytes), one write and one read port
`timescale 1ns / 1ps
`default_nettype none

module vms_mem_bank
    import vms_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bank_req_t         req,
    output logic [DATA_W-1:0]      rdata
);

    logic [DATA_W-1:0]     mem_reg [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic                  same_addr;

    assign same_addr = req.we && (req.waddr == req.raddr);

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        // read during write returns the new byte
        if (req.re)
        begin
            rd_data_reg <= same_addr ? req.wdata : mem_reg[req.raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_valid_reg <= valid_reg[req.raddr] || same_addr;
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/vms_regfile.sv =====
// register file R0..RF, two read ports and one write port
`timescale 1ns / 1ps
`default_nettype none

module vms_regfile
    import vms_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire rf_req_t      req,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0]    rf_reg [REG_DEPTH];
    logic [REG_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;
    logic                 rd_a_valid_reg;
    logic                 rd_b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            rf_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_a_reg <= rf_reg[req.raddr_a];
            rd_b_reg <= rf_reg[req.raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_a_valid_reg <= valid_reg[req.raddr_a];
                rd_b_valid_reg <= valid_reg[req.raddr_b];
            end
        end
    end

    assign rdata_a = rd_a_valid_reg ? rd_a_reg : '0;
    assign rdata_b = rd_b_valid_reg ? rd_b_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/vole_machine_step.sv =====
// top level of the vole machine step block: sequencer around memory and registers
// steps: an executed instruction goes through the decode and execute states before its result
// is registered; a program byte write, a zero fetch or a step while halted completes in decode.
// a new request is taken in idle, or in execute once the result can go out, so its fetch read overlaps that execute
// reset: pc = 48, halt clear, memory and registers read zero through per-entry valid
// bits that reset clears at once, so there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "vole_machine_step_assert.svh"

module vole_machine_step
    import vms_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_data,
    vms_req_if.sink                req,
    vms_rsp_if.source              rsp
);

    typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_EXEC} state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    pc_reg, pc_next;
    logic                 halt_reg, halt_next;
    logic                 item_op_reg, item_op_next;
    logic [ADDR_W-1:0]    item_addr_reg, item_addr_next;
    logic [DATA_W-1:0]    item_data_reg, item_data_next;
    logic [WORD_W-1:0]    ir_reg, ir_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_payload_t         rsp_data_reg, rsp_data_next;

    bank_req_t            bank_req [2];
    logic [DATA_W-1:0]    bank_rd [2];
    rf_req_t              rf_req;
    logic [DATA_W-1:0]    rf_rd_a;
    logic [DATA_W-1:0]    rf_rd_b;

    logic                 can_complete;
    logic                 req_xfer;

    logic [DATA_W-1:0]    dc_b1;
    logic [DATA_W-1:0]    dc_b2;
    logic [3:0]           dc_code;

    logic [3:0]           ex_code;
    logic [REG_IDX_W-1:0] ex_r;
    logic [REG_IDX_W-1:0] ex_t;
    logic [DATA_W-1:0]    ex_xy;
    logic [DATA_W-1:0]    ex_mem;
    logic                 ex_jump;
    logic [ADDR_W-1:0]    exec_pc;

    logic [ADDR_W-1:0]    fetch_pc;
    logic [ADDR_W-1:0]    fetch_pc1;
    logic [ADDR_W-1:0]    fetch_even;
    logic [ADDR_W-1:0]    fetch_odd;

    vms_mem_bank u_bank_even (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (bank_req[0]),
        .rdata (bank_rd[0])
    );

    vms_mem_bank u_bank_odd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (bank_req[1]),
        .rdata (bank_rd[1])
    );

    vms_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rf_req),
        .rdata_a (rf_rd_a),
        .rdata_b (rf_rd_b)
    );

    assign can_complete = !rsp_valid_reg || rsp.ready;
    assign req.ready    = (state_reg == ST_IDLE) || ((state_reg == ST_EXEC) && can_complete);
    assign req_xfer     = req.valid && req.ready;

    // the two instruction bytes always sit in different banks
    assign dc_b1   = pc_reg[0] ? bank_rd[1] : bank_rd[0];
    assign dc_b2   = pc_reg[0] ? bank_rd[0] : bank_rd[1];
    assign dc_code = dc_b1[7:4];

    assign ex_code = ir_reg[15:12];
    assign ex_r    = ir_reg[11:8];
    assign ex_t    = ir_reg[3:0];
    assign ex_xy   = ir_reg[7:0];
    assign ex_mem  = ex_xy[0] ? bank_rd[1] : bank_rd[0];
    assign ex_jump = (ex_code == OP_JUMP) && (rf_rd_a == rf_rd_b);
    assign exec_pc = ex_jump ? ex_xy : pc_reg;

    // a transfer in the execute cycle fetches from the pc this instruction leaves
    assign fetch_pc   = (state_reg == ST_EXEC) ? exec_pc : pc_reg;
    assign fetch_pc1  = fetch_pc + 8'd1;
    assign fetch_even = fetch_pc[0] ? fetch_pc1 : fetch_pc;
    assign fetch_odd  = fetch_pc[0] ? fetch_pc : fetch_pc1;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        item_op_next   = item_op_reg;
        item_addr_next = item_addr_reg;
        item_data_next = item_data_reg;
        ir_next        = ir_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        bank_req[0]    = '0;
        bank_req[1]    = '0;
        rf_req         = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    pc_next = cfg_data;
                end
            end
            ST_DECODE:
            begin
                if (item_op_reg == ITEM_WRITE)
                begin
                    if (can_complete)
                    begin
                        bank_req[item_addr_reg[0]].we    = 1'b1;
                        bank_req[item_addr_reg[0]].waddr = item_addr_reg[ADDR_W-1:1];
                        bank_req[item_addr_reg[0]].wdata = item_data_reg;
                        rsp_valid_next                   = 1'b1;
                        rsp_data_next                    = '0;
                        rsp_data_next.pc_after           = pc_reg;
                        rsp_data_next.is_halted          = halt_reg;
                        state_next                       = ST_IDLE;
                    end
                end
                else if (halt_reg || (dc_b1 == '0))
                begin
                    if (can_complete)
                    begin
                        rsp_valid_next           = 1'b1;
                        rsp_data_next            = '0;
                        rsp_data_next.pc_after   = pc_reg;
                        rsp_data_next.is_halted  = halt_reg;
                        rsp_data_next.zero_fetch = !halt_reg;
                        state_next               = ST_IDLE;
                    end
                end
                else
                begin
                    ir_next = {dc_b1, dc_b2};
                    pc_next = pc_reg + 8'd2;
                    // operand reads: memory byte at XY and up to two registers
                    bank_req[0].re    = 1'b1;
                    bank_req[0].raddr = dc_b2[ADDR_W-1:1];
                    bank_req[1].re    = 1'b1;
                    bank_req[1].raddr = dc_b2[ADDR_W-1:1];
                    rf_req.re         = 1'b1;
                    rf_req.raddr_a    = ((dc_code == OP_MOVE) || (dc_code == OP_ADD))
                                        ? dc_b2[7:4] : dc_b1[3:0];
                    rf_req.raddr_b    = (dc_code == OP_ADD) ? dc_b2[3:0] : REG_R0;
                    state_next        = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (can_complete)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next               = '0;
                    rsp_data_next.pc_after      = exec_pc;
                    rsp_data_next.executed_word = ir_reg;
                    rsp_data_next.is_halted     = halt_reg || (ex_code == OP_HALT);
                    pc_next                     = exec_pc;
                    halt_next                   = halt_reg || (ex_code == OP_HALT);
                    state_next                  = ST_IDLE;
                    unique case (ex_code)
                        OP_LOAD:
                        begin
                            rf_req.we    = 1'b1;
                            rf_req.waddr = ex_r;
                            rf_req.wdata = ex_mem;
                        end
                        OP_LOADI:
                        begin
                            rf_req.we    = 1'b1;
                            rf_req.waddr = ex_r;
                            rf_req.wdata = ex_xy;
                        end
                        OP_MOVE:
                        begin
                            rf_req.we    = 1'b1;
                            rf_req.waddr = ex_t;
                            rf_req.wdata = rf_rd_a;
                        end
                        OP_ADD:
                        begin
                            rf_req.we    = 1'b1;
                            rf_req.waddr = ex_r;
                            rf_req.wdata = rf_rd_a + rf_rd_b;
                        end
                        OP_STORE:
                        begin
                            bank_req[ex_xy[0]].we      = 1'b1;
                            bank_req[ex_xy[0]].waddr   = ex_xy[ADDR_W-1:1];
                            bank_req[ex_xy[0]].wdata   = rf_rd_a;
                            rsp_data_next.screen_valid = (ex_xy == '0);
                            rsp_data_next.screen_byte  = (ex_xy == '0) ? rf_rd_a : '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_data_next.reg_written = rf_req.we;
                    rsp_data_next.reg_number  = rf_req.waddr;
                    rsp_data_next.reg_value   = rf_req.wdata;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (req_xfer)
        begin
            state_next        = ST_DECODE;
            item_op_next      = req.opcode;
            item_addr_next    = req.address;
            item_data_next    = req.data;
            bank_req[0].re    = 1'b1;
            bank_req[0].raddr = fetch_even[ADDR_W-1:1];
            bank_req[1].re    = 1'b1;
            bank_req[1].raddr = fetch_odd[ADDR_W-1:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= START_ADDRESS_RESET;
            halt_reg      <= 1'b0;
            item_op_reg   <= ITEM_WRITE;
            item_addr_reg <= '0;
            item_data_reg <= '0;
            ir_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            item_op_reg   <= item_op_next;
            item_addr_reg <= item_addr_next;
            item_data_reg <= item_data_next;
            ir_reg        <= ir_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.pc_after      = rsp_data_reg.pc_after;
    assign rsp.executed_word = rsp_data_reg.executed_word;
    assign rsp.is_halted     = rsp_data_reg.is_halted;
    assign rsp.zero_fetch    = rsp_data_reg.zero_fetch;
    assign rsp.screen_valid  = rsp_data_reg.screen_valid;
    assign rsp.screen_byte   = rsp_data_reg.screen_byte;
    assign rsp.reg_written   = rsp_data_reg.reg_written;
    assign rsp.reg_number    = rsp_data_reg.reg_number;
    assign rsp.reg_value     = rsp_data_reg.reg_value;

    `VMS_ASSERT(a_no_xfer_in_decode, clk, rst_n,
        (state_reg != ST_DECODE) || !req.ready, "request ready in decode stage")
    `VMS_ASSERT_NEXT(a_xfer_to_decode, clk, rst_n,
        req_xfer, state_reg == ST_DECODE, "transfer did not enter decode")
    `VMS_ASSERT_NEXT(a_exec_stall_holds, clk, rst_n,
        (state_reg == ST_EXEC) && !can_complete,
        (state_reg == ST_EXEC) && $stable(ir_reg), "stalled execute lost its instruction")
    `VMS_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_reg, halt_reg, "halt flag cleared")
    `VMS_ASSERT(a_one_bank_write, clk, rst_n,
        !(bank_req[0].we && bank_req[1].we), "both banks written in one cycle")

endmodule

`default_nettype wire

// ===== tb/vole_machine_step_test.sv =====
// self-checking testbench for the vole machine step block
`timescale 1ns / 1ps

module vole_machine_step_test;
    import vms_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 165;
    localparam int IDLE_PERCENT = 9;

    // a code with no operation behind it
    localparam logic [3:0] OP_UNUSED = 4'hD;

    typedef struct {
        logic         op;
        logic [7:0]   addr;
        logic [7:0]   data;
        bit           typed;
        rsp_payload_t want;
    } stim_row_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [ADDR_W-1:0] cfg_data;

    vms_req_if req ();
    vms_rsp_if rsp ();

    vole_machine_step dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .rsp      (rsp)
    );

    // machine state as the testbench sees it
    logic [7:0] vole_mem [256];
    logic [7:0] vole_regs [16];
    logic [7:0] vole_pc;
    logic       vole_halted;

    rsp_payload_t pending_results [$];
    stim_row_t    directed_rows [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           quiet_stretch = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_payload_t result_of(
        input logic [7:0] pc, input logic [15:0] word, input logic halted,
        input logic zf, input logic sv, input logic [7:0] sb,
        input logic rw, input logic [3:0] rn, input logic [7:0] rv);
        rsp_payload_t res;
        res.pc_after      = pc;
        res.executed_word = word;
        res.is_halted     = halted;
        res.zero_fetch    = zf;
        res.screen_valid  = sv;
        res.screen_byte   = sb;
        res.reg_written   = rw;
        res.reg_number    = rn;
        res.reg_value     = rv;
        return res;
    endfunction

    // advances the machine state by one item and returns what it reports
    function automatic rsp_payload_t machine_step(
        input logic op, input logic [7:0] addr, input logic [7:0] data);
        rsp_payload_t res;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] next_pc;
        logic [3:0] code;
        logic [3:0] r;
        logic [3:0] s;
        logic [3:0] t;
        res = '0;
        if (op == ITEM_WRITE)
        begin
            vole_mem[addr] = data;
        end
        else if (!vole_halted)
        begin
            b1 = vole_mem[vole_pc];
            if (b1 == 8'h00)
            begin
                res.zero_fetch = 1'b1;
            end
            else
            begin
                next_pc = vole_pc + 8'd1;
                b2 = vole_mem[next_pc];
                code = b1[7:4];
                r = b1[3:0];
                s = b2[7:4];
                t = b2[3:0];
                res.executed_word = {b1, b2};
                vole_pc = vole_pc + 8'd2;
                case (code)
                    OP_LOAD:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_number  = r;
                        res.reg_value   = vole_mem[b2];
                    end
                    OP_LOADI:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_number  = r;
                        res.reg_value   = b2;
                    end
                    OP_STORE:
                    begin
                        vole_mem[b2] = vole_regs[r];
                        if (b2 == 8'h00)
                        begin
                            res.screen_valid = 1'b1;
                            res.screen_byte  = vole_regs[r];
                        end
                    end
                    OP_MOVE:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_number  = t;
                        res.reg_value   = vole_regs[s];
                    end
                    OP_ADD:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_number  = r;
                        res.reg_value   = vole_regs[s] + vole_regs[t];
                    end
                    OP_JUMP:
                    begin
                        if (vole_regs[r] == vole_regs[REG_R0])
                            vole_pc = b2;
                    end
                    OP_HALT:
                    begin
                        vole_halted = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (res.reg_written)
                    vole_regs[res.reg_number] = res.reg_value;
            end
        end
        res.pc_after  = vole_pc;
        res.is_halted = vole_halted;
        return res;
    endfunction

    function automatic stim_row_t plain_row(
        input logic op, input logic [7:0] addr, input logic [7:0] data);
        stim_row_t row;
        row.op    = op;
        row.addr  = addr;
        row.data  = data;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(
        input logic op, input logic [7:0] addr, input logic [7:0] data,
        input rsp_payload_t want);
        stim_row_t row;
        row = plain_row(op, addr, data);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic void add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // any instruction except halt, which would stop the machine for good
    function automatic logic [15:0] random_instruction();
        logic [3:0] code;
        logic [3:0] r;
        logic [7:0] b2;
        int pick;
        pick = $urandom_range(6);
        r = 4'($urandom);
        b2 = 8'($urandom);
        case (pick)
            0: code = OP_LOAD;
            1: code = OP_LOADI;
            2:
            begin
                code = OP_STORE;
                if ($urandom_range(3) == 0)
                    b2 = 8'h00;
            end
            3: code = OP_MOVE;
            4: code = OP_ADD;
            5:
            begin
                code = OP_JUMP;
                if ($urandom_range(1) == 0)
                    r = REG_R0;
            end
            default:
            begin
                do
                    code = 4'($urandom);
                while (code inside {OP_LOAD, OP_LOADI, OP_STORE, OP_MOVE, OP_ADD,
                                    OP_JUMP, OP_HALT});
            end
        endcase
        return {code, r, b2};
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // called just after a falling edge, returns just after a falling edge
    task automatic send_item(
        input logic op, input logic [7:0] addr, input logic [7:0] data,
        input bit typed, input rsp_payload_t want);
        rsp_payload_t predicted;
        while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        predicted = machine_step(op, addr, data);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        req.valid   <= 1'b1;
        req.opcode  <= op;
        req.address <= addr;
        req.data    <= data;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_byte(input logic [7:0] addr, input logic [7:0] data);
        send_item(ITEM_WRITE, addr, data, 1'b0, '0);
    endtask

    // steps the machine, or instead rewrites a halt opcode sitting at pc
    task automatic exec_step();
        logic [3:0] nibble;
        if (vole_mem[vole_pc][7:4] == OP_HALT)
        begin
            do
                nibble = 4'($urandom);
            while (nibble == OP_HALT);
            write_byte(vole_pc, {nibble, 4'($urandom)});
        end
        else
        begin
            send_item(ITEM_EXEC, 8'($urandom), 8'($urandom), 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_start(input logic [7:0] value);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        vole_pc = value;
    endtask

    task automatic program_burst(input int count, input int extra);
        logic [15:0] instr;
        logic [7:0]  base;
        base = vole_pc;
        for (int k = 0; k < count; k++)
        begin
            instr = random_instruction();
            write_byte(base, instr[15:8]);
            write_byte(base + 8'd1, instr[7:0]);
            base = base + 8'd2;
        end
        for (int k = 0; k < count + extra; k++)
            exec_step();
    endtask

    always @(negedge clk)
        rsp.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_results
        rsp_payload_t got;
        rsp_payload_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = result_of(rsp.pc_after, rsp.executed_word, rsp.is_halted,
                            rsp.zero_fetch, rsp.screen_valid, rsp.screen_byte,
                            rsp.reg_written, rsp.reg_number, rsp.reg_value);
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending, pc_after %h",
                                          got.pc_after));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.pc_after !== want.pc_after)
                    report_mismatch($sformatf("pc_after %h, want %h",
                                              got.pc_after, want.pc_after));
                if (got.executed_word !== want.executed_word)
                    report_mismatch($sformatf("executed_word %h, want %h",
                                              got.executed_word, want.executed_word));
                if (got.is_halted !== want.is_halted)
                    report_mismatch($sformatf("is_halted %b, want %b",
                                              got.is_halted, want.is_halted));
                if (got.zero_fetch !== want.zero_fetch)
                    report_mismatch($sformatf("zero_fetch %b, want %b",
                                              got.zero_fetch, want.zero_fetch));
                if (got.screen_valid !== want.screen_valid)
                    report_mismatch($sformatf("screen_valid %b, want %b",
                                              got.screen_valid, want.screen_valid));
                if (got.screen_byte !== want.screen_byte)
                    report_mismatch($sformatf("screen_byte %h, want %h",
                                              got.screen_byte, want.screen_byte));
                if (got.reg_written !== want.reg_written)
                    report_mismatch($sformatf("reg_written %b, want %b",
                                              got.reg_written, want.reg_written));
                if (got.reg_number !== want.reg_number)
                    report_mismatch($sformatf("reg_number %h, want %h",
                                              got.reg_number, want.reg_number));
                if (got.reg_value !== want.reg_value)
                    report_mismatch($sformatf("reg_value %h, want %h",
                                              got.reg_value, want.reg_value));
            end
        end
    end

    initial
    begin : stimulus
        int phase_end;
        int items_done;
        int pick;
        int extra;
        req.valid   = 1'b0;
        req.opcode  = ITEM_WRITE;
        req.address = '0;
        req.data    = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;

        for (int i = 0; i < 256; i++)
            vole_mem[i] = 8'h00;
        for (int i = 0; i < 16; i++)
            vole_regs[i] = 8'h00;
        vole_pc     = START_ADDRESS_RESET;
        vole_halted = 1'b0;

        // short program at the reset start address covering every operation except halt
        add_row(typed_row(ITEM_EXEC, 8'h00, 8'h00,
            result_of(8'h30, 16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 4'h0, 8'h00)));
        add_row(typed_row(ITEM_WRITE, 8'h30, {OP_LOADI, 4'hA},
            result_of(8'h30, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 4'h0, 8'h00)));
        add_row(typed_row(ITEM_WRITE, 8'h31, 8'hFF,
            result_of(8'h30, 16'h0000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 4'h0, 8'h00)));
        add_row(typed_row(ITEM_EXEC, 8'hFF, 8'hFF,
            result_of(8'h32, 16'h2AFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 4'hA, 8'hFF)));
        add_row(plain_row(ITEM_WRITE, 8'h32, {OP_ADD, 4'hB}));
        add_row(plain_row(ITEM_WRITE, 8'h33, 8'hAA));
        add_row(plain_row(ITEM_EXEC, 8'h00, 8'h00));
        // store to address zero shows up on the screen
        add_row(plain_row(ITEM_WRITE, 8'h34, {OP_STORE, 4'hB}));
        add_row(plain_row(ITEM_WRITE, 8'h35, 8'h00));
        add_row(plain_row(ITEM_EXEC, 8'h00, 8'h00));
        add_row(plain_row(ITEM_WRITE, 8'h36, {OP_LOAD, REG_R0}));
        add_row(plain_row(ITEM_WRITE, 8'h37, 8'h00));
        add_row(plain_row(ITEM_EXEC, 8'h00, 8'h00));
        add_row(plain_row(ITEM_WRITE, 8'h38, {OP_MOVE, 4'h0}));
        add_row(plain_row(ITEM_WRITE, 8'h39, 8'hB1));
        add_row(plain_row(ITEM_EXEC, 8'h00, 8'h00));
        // r1 equals r0 here, so the jump is taken
        add_row(plain_row(ITEM_WRITE, 8'h3A, {OP_JUMP, 4'h1}));
        add_row(plain_row(ITEM_WRITE, 8'h3B, 8'h40));
        add_row(plain_row(ITEM_EXEC, 8'h00, 8'h00));
        add_row(plain_row(ITEM_WRITE, 8'h40, {OP_UNUSED, 4'h5}));
        add_row(plain_row(ITEM_WRITE, 8'h41, 8'h12));
        add_row(plain_row(ITEM_EXEC, 8'h00, 8'h00));
        add_row(plain_row(ITEM_WRITE, 8'hFF, 8'hFF));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);

        items_done = 0;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
                set_start(8'h00);
            else if (p == 1)
                set_start(8'hFF);
            else
                set_start(8'($urandom));
            quiet_stretch = (p == 3);
            phase_end = items_done + PHASE_ITEMS;
            while (items_done < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    pick = $urandom_range(1, 6);
                    extra = $urandom_range(2);
                    program_burst(pick, extra);
                    items_done += 3 * pick + extra;
                end
                else if (pick < 90)
                begin
                    write_byte(8'($urandom), 8'($urandom));
                    items_done++;
                end
                else
                begin
                    exec_step();
                    items_done++;
                end
            end
        end
        quiet_stretch = 1'b0;

        // halt last, since only reset clears it
        write_byte(vole_pc, {OP_HALT, 4'h0});
        write_byte(vole_pc + 8'd1, 8'h00);
        send_item(ITEM_EXEC, 8'($urandom), 8'($urandom), 1'b0, '0);
        send_item(ITEM_EXEC, 8'($urandom), 8'($urandom), 1'b0, '0);
        write_byte(8'($urandom), 8'($urandom));
        set_start(8'h30);
        send_item(ITEM_EXEC, 8'($urandom), 8'($urandom), 1'b0, '0);

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
